// ===== rtl/rcas_pkg.sv =====
// Shared types and constants for the RC stick arming supervisor.
// Used by the channel interfaces, the core and its checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcas_pkg;

    // Field widths fixed by the channel and register definitions.
    localparam int CH_W       = 12;
    localparam int YAW_LVL_W  = 11;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CH_NUM     = 4;

    // Stored channel positions.
    localparam logic [1:0] CH_ROL = 2'd0;
    localparam logic [1:0] CH_PIT = 2'd1;
    localparam logic [1:0] CH_THR = 2'd2;
    localparam logic [1:0] CH_YAW = 2'd3;

    // Link state codes.
    localparam logic [1:0] LINK_NONE  = 2'd0;
    localparam logic [1:0] LINK_RADIO = 2'd1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_WIDTH      = 3'd0,
        CFG_YAW_GESTURE_LEVEL = 3'd1,
        CFG_THR_GESTURE_LEVEL = 3'd2,
        CFG_LOW_STICK_LEVEL   = 3'd3,
        CFG_FLIP_CANCEL_LEVEL = 3'd4,
        CFG_ARM_HOLD_TICKS    = 3'd5,
        CFG_CAL_HOLD_TICKS    = 3'd6,
        CFG_LINK_LOSS_TICKS   = 3'd7
    } cfg_reg_t;

    // Register reset values.
    localparam logic [CH_W-1:0]        CENTER_WIDTH_RST = 12'd1500;
    localparam logic [YAW_LVL_W-1:0]   YAW_LEVEL_RST    = 11'd200;
    localparam logic signed [CH_W-1:0] THR_LEVEL_RST    = -12'sd200;
    localparam logic signed [CH_W-1:0] LOW_LEVEL_RST    = -12'sd300;
    localparam logic signed [CH_W-1:0] FLIP_LEVEL_RST   = -12'sd400;
    localparam logic [CNT_W-1:0]       ARM_HOLD_RST     = 16'd1000;
    localparam logic [CNT_W-1:0]       CAL_HOLD_RST     = 16'd600;
    localparam logic [CNT_W-1:0]       LINK_LOSS_RST    = 16'd500;

    // One tick of receiver and flight state.
    typedef struct packed {
        logic [CH_W-1:0] new_roll;
        logic [CH_W-1:0] new_pitch;
        logic [CH_W-1:0] new_throttle;
        logic [CH_W-1:0] new_yaw;
        logic            rx_valid;
        logic [1:0]      link_state;
        logic            flip_active;
    } in_word_t;

    // One tick of supervisor results.
    typedef struct packed {
        logic armed;
        logic locked;
        logic throttle_low;
        logic arm_event;
        logic calibrate_pulse;
        logic failsafe_event;
        logic flip_cancel;
    } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/rcas_if.sv =====
// Valid/ready channel interfaces for the RC stick arming supervisor.
// Depends on rcas_pkg for the word types.
`timescale 1ns / 1ps
`default_nettype none

// Tick input channel.
interface rcas_in_if;
    logic               valid;
    logic               ready;
    rcas_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface rcas_out_if;
    logic                valid;
    logic                ready;
    rcas_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface rcas_cfg_if;
    logic                                valid;
    logic                                ready;
    rcas_pkg::cfg_reg_t                  index;
    logic [rcas_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rc_stick_arming_supervisor_core.sv =====
// RC stick arming supervisor: stick gestures, calibration request and link-loss fail-safe.
// Depends on rcas_pkg and the channel interfaces in rcas_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Word
// --------+-----------+-----------------------------------------------
// cmd     | in        | four pulse widths, rx_valid, link_state, flip_active
// rsp     | out       | armed, locked, throttle_low and four event flags
// cfg     | in        | register index and write data, always ready
//
// One word per cycle while the result is not stalled: a word is held in the input
// register, then its update of counters and flags loads the result register.
// A result word passes through the input register and then the result register,
// and can be taken at an edge with rsp.ready high.
// A stalled result holds the input register; cmd.ready stays high while the
// input register is empty or its word moves on. Reset clears supervisor state, counters and valid flags.

module rc_stick_arming_supervisor_core (
    input  wire            clk,
    input  wire            rst_n,
    rcas_in_if.sink        cmd,
    rcas_out_if.source     rsp,
    rcas_cfg_if.sink       cfg
);

    localparam int CW = rcas_pkg::CH_W;
    localparam int NW = rcas_pkg::CNT_W;

    // Configuration registers.
    logic [CW-1:0]                    center_reg;
    logic [rcas_pkg::YAW_LVL_W-1:0]   yaw_lvl_reg;
    logic signed [CW-1:0]             thr_lvl_reg;
    logic signed [CW-1:0]             low_lvl_reg;
    logic signed [CW-1:0]             flip_lvl_reg;
    logic [NW-1:0]                    arm_hold_reg;
    logic [NW-1:0]                    cal_hold_reg;
    logic [NW-1:0]                    link_ticks_reg;

    // Pipeline registers.
    logic                 in_valid_reg;
    rcas_pkg::in_word_t   in_word_reg;
    logic                 out_valid_reg;
    rcas_pkg::out_word_t  out_word_reg;
    rcas_pkg::out_word_t  out_word_next;

    // Supervisor state.
    logic [CW-1:0] store_reg [rcas_pkg::CH_NUM];
    logic [CW-1:0] store_next [rcas_pkg::CH_NUM];
    logic [NW-1:0] hold_cnt_reg, hold_cnt_next;
    logic [NW-1:0] cal_cnt_reg, cal_cnt_next;
    logic [NW-1:0] link_cnt_reg, link_cnt_next;
    logic          armed_reg, armed_next;
    logic          locked_reg, locked_next;

    // Datapath signals.
    logic                 advance;
    logic                 fire;
    logic [CW-1:0]        sel [rcas_pkg::CH_NUM];
    logic signed [CW:0]   thr_c, pit_c, yaw_c;
    logic signed [CW:0]   thr_g, low_l, flip_l, yaw_pos, yaw_neg;
    logic                 in_region;
    logic [NW-1:0]        hold_inc, cal_inc, link_inc;
    logic                 cal_cond;
    logic                 fs_fire;

    // Handshake: the result register empties or is taken, so the word moves on.
    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_word_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg     <= rcas_pkg::CENTER_WIDTH_RST;
            yaw_lvl_reg    <= rcas_pkg::YAW_LEVEL_RST;
            thr_lvl_reg    <= rcas_pkg::THR_LEVEL_RST;
            low_lvl_reg    <= rcas_pkg::LOW_LEVEL_RST;
            flip_lvl_reg   <= rcas_pkg::FLIP_LEVEL_RST;
            arm_hold_reg   <= rcas_pkg::ARM_HOLD_RST;
            cal_hold_reg   <= rcas_pkg::CAL_HOLD_RST;
            link_ticks_reg <= rcas_pkg::LINK_LOSS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                rcas_pkg::CFG_CENTER_WIDTH:      center_reg     <= cfg.data[CW-1:0];
                rcas_pkg::CFG_YAW_GESTURE_LEVEL:
                    yaw_lvl_reg <= cfg.data[rcas_pkg::YAW_LVL_W-1:0];
                rcas_pkg::CFG_THR_GESTURE_LEVEL: thr_lvl_reg    <= $signed(cfg.data[CW-1:0]);
                rcas_pkg::CFG_LOW_STICK_LEVEL:   low_lvl_reg    <= $signed(cfg.data[CW-1:0]);
                rcas_pkg::CFG_FLIP_CANCEL_LEVEL: flip_lvl_reg   <= $signed(cfg.data[CW-1:0]);
                rcas_pkg::CFG_ARM_HOLD_TICKS:    arm_hold_reg   <= cfg.data[NW-1:0];
                rcas_pkg::CFG_CAL_HOLD_TICKS:    cal_hold_reg   <= cfg.data[NW-1:0];
                rcas_pkg::CFG_LINK_LOSS_TICKS:   link_ticks_reg <= cfg.data[NW-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_word_reg <= cmd.data;
        end
    end

    // Stored widths after an optional receiver update, then centred.
    always_comb
    begin
        for (int i = 0; i < rcas_pkg::CH_NUM; i++)
        begin
            sel[i] = store_reg[i];
        end
        if (in_word_reg.rx_valid)
        begin
            sel[rcas_pkg::CH_ROL] = in_word_reg.new_roll;
            sel[rcas_pkg::CH_PIT] = in_word_reg.new_pitch;
            sel[rcas_pkg::CH_THR] = in_word_reg.new_throttle;
            sel[rcas_pkg::CH_YAW] = in_word_reg.new_yaw;
        end
    end

    assign thr_c = $signed({1'b0, sel[rcas_pkg::CH_THR]}) - $signed({1'b0, center_reg});
    assign pit_c = $signed({1'b0, sel[rcas_pkg::CH_PIT]}) - $signed({1'b0, center_reg});
    assign yaw_c = $signed({1'b0, sel[rcas_pkg::CH_YAW]}) - $signed({1'b0, center_reg});

    // Thresholds brought to the centred width.
    assign thr_g   = {thr_lvl_reg[CW-1], thr_lvl_reg};
    assign low_l   = {low_lvl_reg[CW-1], low_lvl_reg};
    assign flip_l  = {flip_lvl_reg[CW-1], flip_lvl_reg};
    assign yaw_pos = $signed({2'b00, yaw_lvl_reg});
    assign yaw_neg = -yaw_pos;

    assign in_region = thr_c < thr_g;
    assign hold_inc  = hold_cnt_reg + 1'b1;
    assign cal_inc   = cal_cnt_reg + 1'b1;
    assign link_inc  = link_cnt_reg + 1'b1;
    assign fs_fire   = (in_word_reg.link_state == rcas_pkg::LINK_NONE)
                       && (link_inc >= link_ticks_reg);

    // Gesture, calibration and link-loss update for one tick.
    always_comb
    begin
        hold_cnt_next = hold_cnt_reg;
        cal_cnt_next  = cal_cnt_reg;
        link_cnt_next = link_cnt_reg;
        armed_next    = armed_reg;
        locked_next   = locked_reg;
        out_word_next = '0;
        cal_cond      = 1'b0;

        out_word_next.flip_cancel = in_word_reg.flip_active && (thr_c < flip_l);

        if (in_region)
        begin
            // Yaw hard right arms, hard left disarms; the two never hold together.
            if (yaw_c > yaw_pos)
            begin
                hold_cnt_next = hold_inc;
                if (hold_inc > arm_hold_reg)
                begin
                    armed_next              = 1'b1;
                    locked_next             = 1'b0;
                    out_word_next.arm_event = 1'b1;
                end
            end
            else if (yaw_c < yaw_neg)
            begin
                hold_cnt_next = hold_inc;
                if (hold_inc > arm_hold_reg)
                begin
                    locked_next = 1'b1;
                    armed_next  = 1'b0;
                end
            end

            // Calibration gesture sees the arming result of this tick.
            cal_cond = !armed_next && (thr_c < low_l) && (pit_c < low_l)
                       && (in_word_reg.link_state == rcas_pkg::LINK_RADIO);
            if (cal_cond)
            begin
                if (cal_inc > cal_hold_reg)
                begin
                    out_word_next.calibrate_pulse = 1'b1;
                    cal_cnt_next                  = '0;
                end
                else
                begin
                    cal_cnt_next = cal_inc;
                end
            end
            else
            begin
                cal_cnt_next = '0;
            end
        end
        else
        begin
            hold_cnt_next = '0;
        end

        out_word_next.throttle_low = !((thr_c > low_l) && armed_next);

        // Link-loss timer.
        if (in_word_reg.link_state == rcas_pkg::LINK_NONE)
        begin
            link_cnt_next = fs_fire ? '0 : link_inc;
        end
        out_word_next.failsafe_event = fs_fire;

        out_word_next.armed  = armed_next;
        out_word_next.locked = locked_next;

        // Fail-safe recentres the stored widths for the next tick.
        for (int i = 0; i < rcas_pkg::CH_NUM; i++)
        begin
            store_next[i] = fs_fire ? center_reg : sel[i];
        end
    end

    // State and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rcas_pkg::CH_NUM; i++)
            begin
                store_reg[i] <= '0;
            end
            hold_cnt_reg  <= '0;
            cal_cnt_reg   <= '0;
            link_cnt_reg  <= '0;
            armed_reg     <= 1'b0;
            locked_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                for (int i = 0; i < rcas_pkg::CH_NUM; i++)
                begin
                    store_reg[i] <= store_next[i];
                end
                hold_cnt_reg <= hold_cnt_next;
                cal_cnt_reg  <= cal_cnt_next;
                link_cnt_reg <= link_cnt_next;
                armed_reg    <= armed_next;
                locked_reg   <= locked_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rcas_checker.sv =====
// Port-level checks for the RC stick arming supervisor, bound to the core.
// Depends on rcas_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module rcas_checker (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       rsp_valid,
    input wire                       rsp_ready,
    input wire rcas_pkg::out_word_t  rsp_data
);

    // A stalled result word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result word changed while stalled");

    // Armed and locked exclude each other.
    a_arm_lock: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.armed && rsp_data.locked))
        else $error("armed and locked both set");

    // An arm event leaves the craft armed.
    a_arm_event: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.arm_event |-> rsp_data.armed)
        else $error("arm event without armed flag");

    // Throttle is always reported low while disarmed.
    a_thr_low: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.armed |-> rsp_data.throttle_low)
        else $error("throttle_low clear while not armed");

endmodule

bind rc_stick_arming_supervisor_core rcas_checker u_rcas_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
